@@ src/rlte_pkg.sv @@
package rlte_pkg;

	localparam int SYM_W   = 8;
	localparam int LEN_W   = 14;
	localparam int COL_W   = 6;
	localparam int BRK_W   = 8;
	localparam int DIGIT_W = 3;

	// Defaults for the top-level parameters
	localparam int LINE_WIDTH_DEF = 40;
	localparam int MAX_DIGITS_DEF = 4;

	// Character codes
	localparam logic [SYM_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [SYM_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [SYM_W-1:0] CHAR_NINE  = 8'h39;

	// Byte held in the input stage
	typedef struct packed {
		logic             valid;
		logic [SYM_W-1:0] symbol;
	} in_stage_t;

	// One run descriptor
	typedef struct packed {
		logic [SYM_W-1:0] symbol_out;
		logic [LEN_W-1:0] run_length;
		logic [COL_W-1:0] start_column;
		logic [BRK_W-1:0] line_breaks;
	} run_desc_t;

	// Decoder to result register
	typedef struct packed {
		logic      load;
		run_desc_t desc;
	} emit_t;

endpackage

@@ src/rlte_in_if.sv @@
interface rlte_in_if;
	import rlte_pkg::*;

	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol_in;

	modport source (output valid, output symbol_in, input ready);
	modport sink   (input valid, input symbol_in, output ready);
endinterface

@@ src/rlte_out_if.sv @@
interface rlte_out_if;
	import rlte_pkg::*;

	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol_out;
	logic [LEN_W-1:0] run_length;
	logic [COL_W-1:0] start_column;
	logic [BRK_W-1:0] line_breaks;

	modport source (
		output valid, output symbol_out, output run_length,
		output start_column, output line_breaks, input ready
	);
	modport sink (
		input valid, input symbol_out, input run_length,
		input start_column, input line_breaks, output ready
	);
endinterface

@@ src/rlte_in_stage.sv @@
module rlte_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	rlte_in_if.sink            din,
	input  logic               out_free,
	output rlte_pkg::in_stage_t stage
);
	import rlte_pkg::*;

	logic             valid_s1;
	logic [SYM_W-1:0] symbol_s1;
	logic             advance;
	logic             take;

	assign advance   = valid_s1 && out_free;
	assign din.ready = !valid_s1 || out_free;
	assign take      = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			symbol_s1 <= din.symbol_in;
		end
	end

	assign stage.valid  = valid_s1;
	assign stage.symbol = symbol_s1;

endmodule

@@ src/rlte_decode.sv @@
module rlte_decode #(
	parameter int LINE_WIDTH = rlte_pkg::LINE_WIDTH_DEF,
	parameter int MAX_DIGITS = rlte_pkg::MAX_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rlte_pkg::in_stage_t stage,
	input  logic                out_free,
	output rlte_pkg::emit_t     emit
);
	import rlte_pkg::*;

	localparam int CW    = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
	localparam int RAW_W = 12;  // 10 * (LINE_WIDTH - 1) + 9 < 4096
	localparam logic [CW:0]      LW_C  = (CW+1)'(LINE_WIDTH);
	localparam logic [LEN_W-1:0] LIT_Q = LEN_W'(1 / LINE_WIDTH);
	localparam logic [CW-1:0]    LIT_R = CW'(1 % LINE_WIDTH);

	logic               stopped_q;
	logic [DIGIT_W-1:0] digits_q;
	logic [LEN_W-1:0]   pend_q;    // count so far
	logic [LEN_W-1:0]   pend_div_q; // count / LINE_WIDTH
	logic [CW-1:0]      pend_mod_q; // count % LINE_WIDTH
	logic [CW-1:0]      col_q;

	logic               advance;
	logic               is_digit;
	logic [3:0]         dval;
	logic [RAW_W-1:0]   raw;
	logic [8:0]         ge;
	logic [3:0]         k;
	logic [RAW_W-1:0]   rem_raw;
	logic [LEN_W-1:0]   acc_pend;
	logic [LEN_W-1:0]   acc_div;
	logic [CW-1:0]      acc_mod;

	logic               do_stop;
	logic               do_acc;
	logic               do_run;
	logic [LEN_W-1:0]   len;
	logic [LEN_W-1:0]   len_div;
	logic [CW-1:0]      len_mod;
	logic [CW:0]        col_sum;
	logic               wrap;
	logic [CW-1:0]      col_next;
	logic [LEN_W-1:0]   brk_full;
	logic               emit_ok;

	assign advance  = stage.valid && out_free;
	assign is_digit = (stage.symbol >= CHAR_ZERO) && (stage.symbol <= CHAR_NINE);
	assign dval     = 4'(stage.symbol - CHAR_ZERO);

	// Next decimal digit: keep quotient and remainder by the line width in step
	always_comb begin
		raw = (RAW_W'(pend_mod_q) * RAW_W'(10)) + RAW_W'(dval);
		for (int j = 1; j <= 9; j++) begin
			ge[j-1] = raw >= RAW_W'(j * LINE_WIDTH);
		end
		k        = 4'($countones(ge));
		rem_raw  = raw - (RAW_W'(k) * RAW_W'(LINE_WIDTH));
		acc_mod  = CW'(rem_raw);
		acc_div  = (pend_div_q * LEN_W'(10)) + LEN_W'(k);
		acc_pend = (pend_q * LEN_W'(10)) + LEN_W'(dval);
	end

	always_comb begin
		do_stop = 1'b0;
		do_acc  = 1'b0;
		do_run  = 1'b0;
		if (!stopped_q) begin
			priority if (digits_q == '0 && stage.symbol == CHAR_SPACE) begin
				do_stop = 1'b1;
			end else if (is_digit && digits_q < DIGIT_W'(MAX_DIGITS)) begin
				do_acc = 1'b1;
			end else begin
				do_run = 1'b1;
			end
		end
	end

	// A literal is a run of one
	assign len     = (digits_q == '0) ? LEN_W'(1) : pend_q;
	assign len_div = (digits_q == '0) ? LIT_Q : pend_div_q;
	assign len_mod = (digits_q == '0) ? LIT_R : pend_mod_q;

	assign col_sum  = {1'b0, col_q} + {1'b0, len_mod};
	assign wrap     = col_sum >= LW_C;
	assign col_next = wrap ? CW'(col_sum - LW_C) : CW'(col_sum);
	assign brk_full = len_div + LEN_W'(wrap);
	assign emit_ok  = do_run && (len != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q  <= 1'b0;
			digits_q   <= '0;
			pend_q     <= '0;
			pend_div_q <= '0;
			pend_mod_q <= '0;
			col_q      <= '0;
		end else if (advance) begin
			if (do_stop) begin
				stopped_q <= 1'b1;
			end
			if (do_acc) begin
				digits_q   <= digits_q + DIGIT_W'(1);
				pend_q     <= acc_pend;
				pend_div_q <= acc_div;
				pend_mod_q <= acc_mod;
			end
			if (do_run) begin
				digits_q   <= '0;
				pend_q     <= '0;
				pend_div_q <= '0;
				pend_mod_q <= '0;
			end
			if (emit_ok) begin
				col_q <= col_next;
			end
		end
	end

	assign emit.load              = advance && emit_ok;
	assign emit.desc.symbol_out   = stage.symbol;
	assign emit.desc.run_length   = len;
	assign emit.desc.start_column = COL_W'(16'(col_q));
	assign emit.desc.line_breaks  = BRK_W'(brk_full);

`ifndef SYNTH
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < LW_C)
		else $error("column out of range");
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pend_mod_q} < LW_C)
		else $error("count remainder out of range");
	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		digits_q <= DIGIT_W'(MAX_DIGITS))
		else $error("too many count digits");
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q && !emit.load)
		else $error("output after end of text");
	a_mod_track: assert property (@(posedge clk) disable iff (!arst_n)
		digits_q == '0 |-> pend_q == '0 && pend_div_q == '0 && pend_mod_q == '0)
		else $error("count not cleared after run");
`endif

endmodule

@@ src/rlte_out_stage.sv @@
module rlte_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  rlte_pkg::emit_t emit,
	output logic            out_free,
	rlte_out_if.source      dout
);
	import rlte_pkg::*;

	logic      valid_q;
	run_desc_t desc_q;

	assign out_free = !valid_q || dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit.load) begin
			valid_q <= 1'b1;
		end else if (dout.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			desc_q <= emit.desc;
		end
	end

	assign dout.valid        = valid_q;
	assign dout.symbol_out   = desc_q.symbol_out;
	assign dout.run_length   = desc_q.run_length;
	assign dout.start_column = desc_q.start_column;
	assign dout.line_breaks  = desc_q.line_breaks;

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !dout.ready |-> !emit.load)
		else $error("result overwritten while stalled");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !dout.ready |=> valid_q && $stable(desc_q))
		else $error("stalled result changed");
	a_load_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		emit.load |-> emit.desc.run_length != '0)
		else $error("zero-length run issued");
`endif

endmodule

@@ src/run_length_text_expander_core.sv @@
// Run-length text expander core.
// din  : one encoded text byte per transfer (valid/ready, symbol_in).
// dout : one run descriptor per transfer (symbol_out, run_length,
//        start_column, line_breaks); the consumer expands it to bytes.
// Up to MAX_DIGITS leading decimal digits form a repeat count; the next byte
// is the symbol. A byte with no count is a run of one. A zero count gives no
// descriptor. A space with no count pending ends the text: every later byte
// is accepted and dropped until reset.
// Throughput: one byte per cycle while dout is not stalled. The running
// count is kept as quotient and remainder by LINE_WIDTH, so each byte needs
// only one multiply-by-ten step and one wrap compare on the column.
// Path: the byte that closes a run passes the input register, then the
// result register, from which its descriptor is driven onto dout.
// Stall: a held result stays in the output register; one more byte is still
// taken into the input register, after which din.ready follows dout.ready.
// Reset (arst_n low): count, digit counter and column clear, end-of-text
// flag clears, both registers empty. No clearing pass is needed.
module run_length_text_expander_core #(
	parameter int LINE_WIDTH = rlte_pkg::LINE_WIDTH_DEF,  // 1..64
	parameter int MAX_DIGITS = rlte_pkg::MAX_DIGITS_DEF   // 1..4
) (
	input  logic       clk,
	input  logic       arst_n,
	rlte_in_if.sink    din,
	rlte_out_if.source dout
);
	import rlte_pkg::*;

	in_stage_t stage;   // byte waiting for decode
	emit_t     emit;    // descriptor into the result register
	logic      out_free; // result register can take a new descriptor

	rlte_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (din),
		.out_free (out_free),
		.stage    (stage)
	);

	// Count accumulation, end-of-text flag and column tracking
	rlte_decode #(
		.LINE_WIDTH (LINE_WIDTH),
		.MAX_DIGITS (MAX_DIGITS)
	) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage    (stage),
		.out_free (out_free),
		.emit     (emit)
	);

	rlte_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.emit     (emit),
		.out_free (out_free),
		.dout     (dout)
	);

endmodule
